### rtl/core/ahosc_pkg.sv
`default_nettype none

package ahosc_pkg;

    localparam int unsigned PHASE_W = 32;
    localparam int unsigned LAYER_W = 5;
    localparam int unsigned HARM_W  = 7;
    localparam int unsigned TERM_W  = 16;
    localparam int unsigned QVAL_W  = 15;
    localparam int unsigned SUM_W   = 25;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic signed [TERM_W-1:0] AMP     = 16'sd32767;
    localparam logic signed [SUM_W-1:0]  SUM_MAX = 25'sh0FFFFFF;
    localparam logic signed [SUM_W-1:0]  SUM_MIN = 25'sh1000000;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic [PHASE_W-1:0] LAYER_OFFSET_RST = 32'd21474836;
    localparam logic [3:0]         LAYER_COUNT_RST  = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_STEP     = 3'd0,
        CFG_HARMONIC_COUNT = 3'd1,
        CFG_WAVE_MODE      = 3'd2,
        CFG_LAYER_COUNT    = 3'd3,
        CFG_LAYER_OFFSET   = 3'd4
    } ahosc_cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } ahosc_state_t;

    typedef struct packed {
        logic [PHASE_W-1:0] base;
        logic [PHASE_W-1:0] offset;
        logic [LAYER_W-1:0] layers;
        logic [HARM_W-1:0]  harms;
        logic               square;
    } ahosc_job_t;

    function automatic logic [QVAL_W-1:0] quarter_sine(input int unsigned k,
                                                      input int unsigned bits);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] s;
        logic [63:0] r;
        int unsigned n;
        x    = (64'(k) * TWO_PI_Q30) >> bits;
        term = x;
        pos  = x;
        neg  = 64'd0;
        for (n = 1; n <= 9; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        s = (pos > neg) ? pos - neg : 64'd0;
        r = (64'd32767 * s + (64'd1 << 29)) >> 30;
        return r[QVAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/ahosc_wave_unit.sv
`default_nettype none

module ahosc_wave_unit #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  issue,
    input  wire logic                                  square,
    input  wire logic [ahosc_pkg::PHASE_W-1:0]         phase,
    output logic                                       term_vld,
    output logic signed [ahosc_pkg::TERM_W-1:0]        term
);

    localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
    localparam int A_W     = SINE_TABLE_BITS - 1;

    logic [ahosc_pkg::QVAL_W-1:0] qtab [QUARTER+1];

    genvar k;
    generate
        for (k = 0; k <= QUARTER; k++) begin : g_tab
            localparam logic [ahosc_pkg::QVAL_W-1:0] QV =
                ahosc_pkg::quarter_sine(k, SINE_TABLE_BITS);
            assign qtab[k] = QV;
        end
    endgenerate

    logic [SINE_TABLE_BITS-1:0]             idx;
    logic [1:0]                             quad;
    logic [SINE_TABLE_BITS-3:0]             rem;
    logic [A_W-1:0]                         addr;
    logic [ahosc_pkg::QVAL_W-1:0]           qval;
    logic signed [ahosc_pkg::TERM_W-1:0]    sine_val;
    logic signed [ahosc_pkg::TERM_W-1:0]    square_val;
    logic signed [ahosc_pkg::TERM_W-1:0]    term_next;
    logic signed [ahosc_pkg::TERM_W-1:0]    term_reg;
    logic                                   vld_reg;

    always_comb begin
        idx  = phase[ahosc_pkg::PHASE_W-1 -: SINE_TABLE_BITS];
        quad = idx[SINE_TABLE_BITS-1:SINE_TABLE_BITS-2];
        rem  = idx[SINE_TABLE_BITS-3:0];
        addr = quad[0] ? A_W'(QUARTER) - {1'b0, rem} : {1'b0, rem};
        qval = qtab[addr];
        sine_val = quad[1] ? -$signed({1'b0, qval}) : $signed({1'b0, qval});
        square_val = ((phase != '0) && !phase[ahosc_pkg::PHASE_W-1]) ?
                     ahosc_pkg::AMP : -ahosc_pkg::AMP;
        term_next = square ? square_val : sine_val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
    end

    assign term_vld = vld_reg;
    assign term     = term_reg;

endmodule

`default_nettype wire

### rtl/core/ahosc_seq.sv
`default_nettype none

module ahosc_seq #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_LAYERS      = 8,
    parameter int MAX_HARMONICS   = 63
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire ahosc_pkg::ahosc_job_t                 job,
    input  wire logic                                  out_free,
    output logic                                       idle,
    output logic                                       done,
    output logic signed [ahosc_pkg::SUM_W-1:0]         sum
);

    localparam int ACC_RAW = 17 + $clog2(MAX_LAYERS * (MAX_HARMONICS + 1));
    localparam int ACC_W   = (ACC_RAW > 25) ? ACC_RAW : 25;

    ahosc_pkg::ahosc_state_t state_reg, state_next;
    ahosc_pkg::ahosc_job_t   job_reg;

    logic [ahosc_pkg::LAYER_W-1:0]  l_reg;
    logic [ahosc_pkg::HARM_W-1:0]   h_reg;
    logic [ahosc_pkg::PHASE_W-1:0]  hp_reg;
    logic [ahosc_pkg::PHASE_W-1:0]  lo_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic                           issue;
    logic                           last_term;
    logic                           harm_wrap;
    logic [ahosc_pkg::PHASE_W-1:0]  phase;
    logic                           term_vld;
    logic signed [ahosc_pkg::TERM_W-1:0] term;

    assign harm_wrap = (h_reg == job_reg.harms);
    assign last_term = harm_wrap &&
                       (l_reg == job_reg.layers - ahosc_pkg::LAYER_W'(1));
    assign phase     = hp_reg + lo_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ahosc_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = (job.layers == '0) ? ahosc_pkg::ST_DRAIN
                                                    : ahosc_pkg::ST_RUN;
                end
            end
            ahosc_pkg::ST_RUN: begin
                if (last_term) begin
                    state_next = ahosc_pkg::ST_DRAIN;
                end
            end
            ahosc_pkg::ST_DRAIN: begin
                if (!term_vld && out_free) begin
                    state_next = ahosc_pkg::ST_IDLE;
                end
            end
            default: state_next = ahosc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        idle  = (state_reg == ahosc_pkg::ST_IDLE);
        issue = (state_reg == ahosc_pkg::ST_RUN);
        done  = (state_reg == ahosc_pkg::ST_DRAIN) && !term_vld && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ahosc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (idle && start) begin
            job_reg <= job;
            l_reg   <= '0;
            h_reg   <= '0;
            hp_reg  <= job.base;
            lo_reg  <= '0;
        end else if (issue) begin
            if (harm_wrap) begin
                h_reg  <= '0;
                hp_reg <= job_reg.base;
                l_reg  <= l_reg + ahosc_pkg::LAYER_W'(1);
                lo_reg <= lo_reg + job_reg.offset;
            end else begin
                h_reg  <= h_reg + ahosc_pkg::HARM_W'(1);
                hp_reg <= hp_reg + job_reg.base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (idle && start) begin
            acc_reg <= '0;
        end else if (term_vld) begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
    end

    always_comb begin
        if (acc_reg > ACC_W'(ahosc_pkg::SUM_MAX)) begin
            sum = ahosc_pkg::SUM_MAX;
        end else if (acc_reg < ACC_W'(ahosc_pkg::SUM_MIN)) begin
            sum = ahosc_pkg::SUM_MIN;
        end else begin
            sum = acc_reg[ahosc_pkg::SUM_W-1:0];
        end
    end

    ahosc_wave_unit #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_wave (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .issue    (issue),
        .square   (job_reg.square),
        .phase    (phase),
        .term_vld (term_vld),
        .term     (term)
    );

endmodule

`default_nettype wire

### rtl/core/additive_harmonic_oscillator.sv
// Additive oscillator: each request is one sample tick and returns one summed sample.
// A single phase adder and wave unit produce one term per cycle, walking every layer
// and every harmonic in turn, so the result goes valid once all layers*(harmonics+1)
// terms are summed (none with zero layers); s_ready stays low until then, and longer
// while an earlier result waits for m_ready.
// Configuration writes are taken at any time but must only be issued while the block
// is idle.
`default_nettype none

module additive_harmonic_oscillator #(
    parameter int SINE_TABLE_BITS = 10,
    parameter int MAX_LAYERS      = 8,
    parameter int MAX_HARMONICS   = 63
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [ahosc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [31:0]                            cfg_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic                                   s_restart,
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic signed [ahosc_pkg::SUM_W-1:0]          m_sample_sum
);

    logic [31:0] phase_step_reg;
    logic [5:0]  harmonic_count_reg;
    logic        wave_mode_reg;
    logic [3:0]  layer_count_reg;
    logic [31:0] layer_offset_reg;
    logic [31:0] base_phase_reg, base_phase_next;
    logic        m_valid_reg, m_valid_next;
    logic signed [ahosc_pkg::SUM_W-1:0] m_sum_reg;

    ahosc_pkg::ahosc_job_t job;
    logic        start;
    logic        idle;
    logic        done;
    logic        out_free;
    logic [31:0] base_used;
    logic signed [ahosc_pkg::SUM_W-1:0] sum;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign start     = s_valid && idle;
    assign out_free  = !m_valid_reg || m_ready;

    assign base_used = s_restart ? '0 : base_phase_reg;

    always_comb begin
        job.base   = base_used;
        job.offset = layer_offset_reg;
        job.layers = (32'(layer_count_reg) > MAX_LAYERS) ?
                     ahosc_pkg::LAYER_W'(MAX_LAYERS) :
                     ahosc_pkg::LAYER_W'(layer_count_reg);
        job.harms  = (32'(harmonic_count_reg) > MAX_HARMONICS) ?
                     ahosc_pkg::HARM_W'(MAX_HARMONICS) :
                     ahosc_pkg::HARM_W'(harmonic_count_reg);
        job.square = wave_mode_reg;
    end

    always_comb begin
        base_phase_next = base_phase_reg;
        if (start) begin
            base_phase_next = base_used + phase_step_reg;
        end
        m_valid_next = m_valid_reg;
        if (done) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg     <= '0;
            harmonic_count_reg <= '0;
            wave_mode_reg      <= 1'b0;
            layer_count_reg    <= ahosc_pkg::LAYER_COUNT_RST;
            layer_offset_reg   <= ahosc_pkg::LAYER_OFFSET_RST;
        end else if (cfg_valid) begin
            case (ahosc_pkg::ahosc_cfg_idx_t'(cfg_index))
                ahosc_pkg::CFG_PHASE_STEP:     phase_step_reg     <= cfg_data;
                ahosc_pkg::CFG_HARMONIC_COUNT: harmonic_count_reg <= cfg_data[5:0];
                ahosc_pkg::CFG_WAVE_MODE:      wave_mode_reg      <= cfg_data[0];
                ahosc_pkg::CFG_LAYER_COUNT:    layer_count_reg    <= cfg_data[3:0];
                ahosc_pkg::CFG_LAYER_OFFSET:   layer_offset_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_phase_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            base_phase_reg <= base_phase_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done) begin
            m_sum_reg <= sum;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_sum = m_sum_reg;

    ahosc_seq #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .MAX_LAYERS      (MAX_LAYERS),
        .MAX_HARMONICS   (MAX_HARMONICS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .job      (job),
        .out_free (out_free),
        .idle     (idle),
        .done     (done),
        .sum      (sum)
    );

endmodule

`default_nettype wire

### rtl/core/ahosc_checker.sv
`default_nettype none

module ahosc_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic signed [ahosc_pkg::SUM_W-1:0] m_sample_sum
);

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous one in progress");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_sum)))
        else $error("stalled result dropped or changed");

endmodule

bind additive_harmonic_oscillator ahosc_checker u_ahosc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_sum (m_sample_sum)
);

`default_nettype wire

### sim/tb_additive_harmonic_oscillator.sv
`default_nettype none

module tb_additive_harmonic_oscillator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TICKS_RANDOM = 450;
    localparam int MAX_LATENCY  = 8 * 64 + 3;
    localparam int QUIET_LIMIT  = 5000;
    localparam int GAP_PCT      = 25;
    localparam int LAYER_CAP    = 8;
    localparam int HARM_CAP     = 63;
    localparam int TERM_PEAK    = 32767;
    localparam longint SAT_HI   = 64'sd16777215;
    localparam longint SAT_LO   = -64'sd16777216;
    localparam bit [63:0] TWO_PI_FIX = 64'd6746518852;
    localparam logic [ahosc_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP = ahosc_pkg::CFG_LAYER_OFFSET;
    localparam int CFG_IDX_MAX  = (1 << ahosc_pkg::CFG_IDX_W) - 1;
    localparam bit WAVE_SINE    = 1'b0;
    localparam bit WAVE_SQUARE  = 1'b1;

    class osc_scoreboard;
        bit [31:0] step_reg;
        bit [5:0]  harm_reg;
        bit        square_reg;
        bit [3:0]  layers_reg;
        bit [31:0] offset_reg;
        bit [31:0] phase_acc;
        int        quarter_wave [257];
        logic signed [ahosc_pkg::SUM_W-1:0] sums_due [$];
        int        errors;

        function new();
            bit [63:0] arg;
            bit [63:0] pw;
            bit [63:0] plus;
            bit [63:0] minus;
            bit [63:0] diff;
            for (int k = 0; k <= 256; k++) begin
                arg   = (64'(k) * TWO_PI_FIX) >> 10;
                pw    = arg;
                plus  = arg;
                minus = 64'd0;
                for (int n = 1; n <= 9; n++) begin
                    pw = (pw * arg) >> 30;
                    pw = (pw * arg) >> 30;
                    pw = pw / 64'((2 * n) * (2 * n + 1));
                    if (n % 2 == 1) begin
                        minus += pw;
                    end else begin
                        plus += pw;
                    end
                end
                diff = (plus > minus) ? plus - minus : 64'd0;
                quarter_wave[k] = int'((64'd32767 * diff + (64'd1 << 29)) >> 30);
            end
            step_reg   = '0;
            harm_reg   = '0;
            square_reg = WAVE_SINE;
            layers_reg = 4'd1;
            offset_reg = 32'd21474836;
            phase_acc  = '0;
            errors     = 0;
        endfunction

        function int sine_at(bit [31:0] ph);
            bit [9:0] idx;
            int v;
            idx = ph[31:22];
            v = idx[8] ? quarter_wave[256 - idx[7:0]] : quarter_wave[idx[7:0]];
            return idx[9] ? -v : v;
        endfunction

        function int square_at(bit [31:0] ph);
            return (ph != 32'd0 && ph < 32'h8000_0000) ? TERM_PEAK : -TERM_PEAK;
        endfunction

        function void write_reg(logic [ahosc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                ahosc_pkg::CFG_PHASE_STEP:     step_reg   = data;
                ahosc_pkg::CFG_HARMONIC_COUNT: harm_reg   = data[5:0];
                ahosc_pkg::CFG_WAVE_MODE:      square_reg = data[0];
                ahosc_pkg::CFG_LAYER_COUNT:    layers_reg = data[3:0];
                ahosc_pkg::CFG_LAYER_OFFSET:   offset_reg = data;
                default: ;
            endcase
        endfunction

        function void note_tick(bit restart);
            int     lim_layers;
            int     lim_harms;
            longint acc;
            bit [31:0] lw;
            bit [31:0] hw;
            bit [31:0] off;
            bit [31:0] ph;
            if (restart) begin
                phase_acc = '0;
            end
            lim_layers = (layers_reg > LAYER_CAP) ? LAYER_CAP : layers_reg;
            lim_harms  = (harm_reg > HARM_CAP) ? HARM_CAP : harm_reg;
            acc = 0;
            for (int l = 0; l < lim_layers; l++) begin
                lw  = l;
                off = lw * offset_reg;
                for (int h = 1; h <= lim_harms + 1; h++) begin
                    hw  = h;
                    ph  = hw * phase_acc + off;
                    acc += square_reg ? square_at(ph) : sine_at(ph);
                end
            end
            if (acc > SAT_HI) begin
                acc = SAT_HI;
            end
            if (acc < SAT_LO) begin
                acc = SAT_LO;
            end
            sums_due.push_back(acc[ahosc_pkg::SUM_W-1:0]);
            phase_acc += step_reg;
        endfunction

        function void check_sample(logic signed [ahosc_pkg::SUM_W-1:0] got);
            logic signed [ahosc_pkg::SUM_W-1:0] want;
            if (sums_due.size() == 0) begin
                $error("sample_sum: expected none, actual %0d", got);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got !== want) begin
                $error("sample_sum: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return sums_due.size();
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ahosc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic s_valid   = 1'b0;
    logic s_ready;
    logic s_restart = 1'b0;
    logic m_valid;
    logic m_ready   = 1'b0;
    logic signed [ahosc_pkg::SUM_W-1:0] m_sample_sum;

    osc_scoreboard sb;
    bit gaps_on = 1'b1;
    int ticks_sent = 0;
    int quiet_cycles = 0;

    additive_harmonic_oscillator u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_sum (m_sample_sum)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
    end

    always @(posedge aclk) begin : monitor
        bit moved;
        moved = 1'b0;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                sb.write_reg(cfg_index, cfg_data);
                moved = 1'b1;
            end
            if (s_valid && s_ready) begin
                sb.note_tick(s_restart);
                moved = 1'b1;
            end
            if (m_valid && m_ready) begin
                sb.check_sample(m_sample_sum);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic [ahosc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    task automatic program_all(input bit [31:0] step, input bit [5:0] harm, input bit mode,
                               input bit [3:0] layers, input bit [31:0] offset);
        cfg_write(ahosc_pkg::CFG_PHASE_STEP, step);
        cfg_write(ahosc_pkg::CFG_HARMONIC_COUNT, 32'(harm));
        cfg_write(ahosc_pkg::CFG_WAVE_MODE, 32'(mode));
        cfg_write(ahosc_pkg::CFG_LAYER_COUNT, 32'(layers));
        cfg_write(ahosc_pkg::CFG_LAYER_OFFSET, offset);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_tick(input bit restart);
        while (gaps_on && $urandom_range(99) < GAP_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        ticks_sent++;
    endtask

    task automatic drain_samples();
        s_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic random_config();
        int r;
        bit [5:0] harm;
        bit [3:0] layers;
        bit [31:0] step;
        if ($urandom_range(99) < 60) begin
            case ($urandom_range(3))
                0: step = $urandom_range(32'd1_000_000, 32'd1_900_000_000);
                1: step = $urandom();
                2: step = {2'($urandom_range(3)), 30'd0};
                default: step = $urandom_range(0, 1000);
            endcase
            cfg_write(ahosc_pkg::CFG_PHASE_STEP, step);
        end
        if ($urandom_range(99) < 60) begin
            r = $urandom_range(99);
            harm = (r < 70) ? 6'($urandom_range(0, 7)) :
                   (r < 90) ? 6'($urandom_range(8, 31)) : 6'($urandom_range(32, 63));
            cfg_write(ahosc_pkg::CFG_HARMONIC_COUNT, {26'($urandom()), harm});
        end
        if ($urandom_range(99) < 50) begin
            cfg_write(ahosc_pkg::CFG_WAVE_MODE, {31'($urandom()), 1'($urandom_range(1))});
        end
        if ($urandom_range(99) < 60) begin
            r = $urandom_range(99);
            if (r < 70) begin
                layers = 4'($urandom_range(1, 2));
            end else if (r < 85) begin
                layers = 4'($urandom_range(0, 4));
            end else begin
                layers = 4'($urandom_range(5, 15));
            end
            cfg_write(ahosc_pkg::CFG_LAYER_COUNT, {28'($urandom()), layers});
        end
        if ($urandom_range(99) < 50) begin
            cfg_write(ahosc_pkg::CFG_LAYER_OFFSET,
                      ($urandom_range(1) != 0) ? $urandom()
                                               : $urandom_range(0, 100_000_000));
        end
        if ($urandom_range(99) < 10) begin
            cfg_write(ahosc_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_TOP + 1, CFG_IDX_MAX)),
                      $urandom());
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int target;
        int phase_no;
        sb = new();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        program_all(32'hFFFF_FFFF, 6'd63, WAVE_SINE, 4'd8, 32'hFFFF_FFFF);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        cfg_write(ahosc_pkg::CFG_WAVE_MODE, 32'(WAVE_SQUARE));
        cfg_valid <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_samples();

        cfg_write(ahosc_pkg::CFG_LAYER_COUNT, 32'd0);
        cfg_valid <= 1'b0;
        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        cfg_write(ahosc_pkg::CFG_LAYER_COUNT, 32'd15);
        cfg_valid <= 1'b0;
        send_tick(1'b0);
        drain_samples();

        cfg_write(ahosc_pkg::CFG_IDX_W'($urandom_range(CFG_IDX_TOP + 1, CFG_IDX_MAX)),
                  $urandom());
        cfg_valid <= 1'b0;
        send_tick(1'b0);
        drain_samples();

        program_all(32'h8000_0000, 6'd0, WAVE_SQUARE, 4'd1, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_samples();

        cfg_write(ahosc_pkg::CFG_PHASE_STEP, 32'h4000_0000);
        cfg_valid <= 1'b0;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b0);
        drain_samples();

        program_all(32'd0, 6'd0, WAVE_SINE, 4'd1, 32'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        drain_samples();

        target = ticks_sent + TICKS_RANDOM;
        phase_no = 0;
        while (ticks_sent < target) begin
            gaps_on = !(phase_no >= 4 && phase_no < 8);
            random_config();
            repeat ($urandom_range(8, 30)) begin
                send_tick($urandom_range(99) < 10);
            end
            drain_samples();
            phase_no++;
        end
        gaps_on = 1'b1;

        repeat (MAX_LATENCY) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

### additive_harmonic_oscillator.f
rtl/core/ahosc_pkg.sv
rtl/core/ahosc_wave_unit.sv
rtl/core/ahosc_seq.sv
rtl/core/additive_harmonic_oscillator.sv
rtl/core/ahosc_checker.sv
sim/tb_additive_harmonic_oscillator.sv
